// File: rtl/ppu_pkg.sv
package ppu_pkg;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] rotation;
        logic [32:0] life_left;
        logic [31:0] life_total;
        logic [15:0] size_start;
        logic [15:0] size_final;
        logic [31:0] color_start;
        logic [31:0] color_final;
    } t_slot;

    typedef struct packed {
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [31:0] center_z;
        logic [31:0] rect_color;
        logic [15:0] rect_size;
        logic [31:0] rect_rotation;
    } t_res;

    localparam int SLOT_W = $bits(t_slot);
    localparam int FRAC_W = 16;

    // floor(x/100) for x below 2^17 as (x*TURN_RECIP) >> TURN_SHIFT
    localparam logic [17:0] TURN_RECIP = 18'd167773;
    localparam int          TURN_SHIFT = 24;
    localparam logic [16:0] TURN_BIAS  = 17'd50;

    localparam logic [2:0] CFG_COLOR_BEGIN = 3'd0;
    localparam logic [2:0] CFG_COLOR_END   = 3'd1;
    localparam logic [2:0] CFG_SIZE_BEGIN  = 3'd2;
    localparam logic [2:0] CFG_SIZE_END    = 3'd3;
    localparam logic [2:0] CFG_SIZE_VAR    = 3'd4;
    localparam logic [2:0] CFG_LIFE_TIME   = 3'd5;
    localparam logic [2:0] CFG_VEL_VAR     = 3'd6;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    function automatic logic [31:0] sat32(input logic [33:0] v);
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            return v[31:0];
        end
        return v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic [7:0] mix8(input logic [7:0] lo, input logic [7:0] hi,
                                        input logic [16:0] f);
        logic [25:0] s;
        s = {18'd0, lo} * {9'd0, 17'h10000 - f} + {18'd0, hi} * {9'd0, f};
        return s[23:16];
    endfunction

    function automatic logic [15:0] mix16(input logic [15:0] lo, input logic [15:0] hi,
                                          input logic [16:0] f);
        logic [33:0] s;
        s = {18'd0, lo} * {17'd0, 17'h10000 - f} + {18'd0, hi} * {17'd0, f};
        return s[31:16];
    endfunction

endpackage

// File: rtl/ppu_ram.sv
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/ppu_div.sv
module ppu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    import ppu_pkg::*;

    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [15:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] sh;
    logic        ge;

    assign sh = {r_rem[31:0], 1'b0};
    assign ge = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? sh - {1'b0, r_den} : sh;
            r_quot <= {r_quot[14:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// File: rtl/particle_pool_update_unit.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: emit/tick fields, tuser: mode
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: rectangle, tlast: last of tick
// cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_data
// Emit: ST_EMUL, ST_EWR. Tick: an empty slot passes ST_SCAN, a retired one ST_LOAD,
// a live one ST_LOAD, ST_MUL, ST_UPD, ST_DIV (16-step divider, skipped if the life
// fraction is 0 or 1), ST_MIX and ST_PUSH; ST_FLUSH ends the tick.
// Reset clears active bits, write slot and valids, presets config; slot memory holds
// no reset. A stalled output holds the walk only when a second rectangle is ready.
module particle_pool_update_unit #(
    parameter int POOL_SIZE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // delta_time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, rand_rotation,
    // rand_velocity, rand_size
    input  logic [287:0] s_axis_tdata,
    // mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // center_x, center_y, center_z, rect_color, rect_size, rect_rotation
    output logic [175:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [47:0]  i_cfg_data
);
    import ppu_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EMUL  = 4'd1;
    localparam logic [3:0] ST_EWR   = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_LOAD  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_UPD   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_MIX   = 4'd8;
    localparam logic [3:0] ST_PUSH  = 4'd9;
    localparam logic [3:0] ST_FLUSH = 4'd10;

    logic [31:0] r_color_begin, r_color_end, r_life_time;
    logic [15:0] r_size_begin, r_size_end, r_size_var;
    logic [47:0] r_vel_var;

    logic [3:0]          r_state;
    logic [AW-1:0]       r_idx, r_wslot;
    logic [POOL_SIZE-1:0] r_active;

    logic [15:0] r_dt, r_rand_rot, r_rand_size;
    logic [95:0] r_pos, r_vel;
    logic [47:0] r_rand_vel;

    logic [32:0] r_jx, r_jy, r_jz, r_js;
    logic [24:0] r_rot0;

    t_slot       r_ent;
    t_slot       rdata, wdata_emit, wdata;
    logic [48:0] r_mx, r_my, r_mz;
    logic [10:0] r_turn;
    logic [32:0] r_life;
    logic [16:0] r_f;
    t_res        r_res, r_pend, r_out;
    logic        r_pend_v, r_out_v, r_out_last;

    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic        div_start, div_done;
    logic [15:0] div_quot;
    logic        out_free, out_load, life_le0;
    logic [34:0] turn_prod;
    logic [17:0] size_sum;
    logic [15:0] size0;

    assign out_free = !r_out_v || m_axis_tready;
    assign out_load = r_pend_v && out_free && (r_state == ST_PUSH || r_state == ST_FLUSH);
    assign s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_begin <= 32'hFFFF_FFFF;
            r_color_end   <= '0;
            r_size_begin  <= 16'd256;
            r_size_end    <= '0;
            r_size_var    <= '0;
            r_life_time   <= 32'd65536;
            r_vel_var     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLOR_BEGIN: r_color_begin <= i_cfg_data[31:0];
                CFG_COLOR_END:   r_color_end   <= i_cfg_data[31:0];
                CFG_SIZE_BEGIN:  r_size_begin  <= i_cfg_data[15:0];
                CFG_SIZE_END:    r_size_end    <= i_cfg_data[15:0];
                CFG_SIZE_VAR:    r_size_var    <= i_cfg_data[15:0];
                CFG_LIFE_TIME:   r_life_time   <= i_cfg_data[31:0];
                CFG_VEL_VAR:     r_vel_var     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // emit arithmetic
    always_comb begin
        size_sum = {2'b00, r_size_begin} + {r_js[32], r_js[32:16]};
        if (size_sum[17]) begin
            size0 = '0;
        end else if (size_sum[16]) begin
            size0 = 16'hFFFF;
        end else begin
            size0 = size_sum[15:0];
        end
        wdata_emit.pos_x       = r_pos[31:0];
        wdata_emit.pos_y       = r_pos[63:32];
        wdata_emit.pos_z       = r_pos[95:64];
        wdata_emit.vel_x       = sat32({{2{r_vel[31]}}, r_vel[31:0]}
                                       + {{9{r_jx[32]}}, r_jx[32:8]});
        wdata_emit.vel_y       = sat32({{2{r_vel[63]}}, r_vel[63:32]}
                                       + {{9{r_jy[32]}}, r_jy[32:8]});
        wdata_emit.vel_z       = sat32({{2{r_vel[95]}}, r_vel[95:64]}
                                       + {{9{r_jz[32]}}, r_jz[32:8]});
        wdata_emit.rotation    = {7'd0, r_rot0};
        wdata_emit.life_left   = {1'b0, r_life_time};
        wdata_emit.life_total  = r_life_time;
        wdata_emit.size_start  = size0;
        wdata_emit.size_final  = r_size_end;
        wdata_emit.color_start = r_color_begin;
        wdata_emit.color_final = r_color_end;
    end

    assign ram_we    = (r_state == ST_EWR) || (r_state == ST_MIX);
    assign ram_waddr = (r_state == ST_EWR) ? r_wslot : r_idx;
    assign wdata     = (r_state == ST_EWR) ? wdata_emit : r_ent;

    ppu_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SIZE)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign div_start = (r_state == ST_UPD) && !(r_life[32] || r_life == '0)
                       && (r_ent.life_total != '0) && (r_life[31:0] < r_ent.life_total);

    ppu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_life[31:0]),
        .i_den   (r_ent.life_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign life_le0  = rdata.life_left[32] || rdata.life_left == '0;
    assign turn_prod = {18'd0, 17'({1'b0, r_dt} + TURN_BIAS)} * {17'd0, TURN_RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_wslot    <= '0;
            r_active   <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (r_out_v && m_axis_tready && !out_load) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_idx   <= '0;
                        r_state <= (s_axis_tuser == MODE_EMIT) ? ST_EMUL : ST_SCAN;
                    end
                end
                ST_EMUL: r_state <= ST_EWR;
                ST_EWR: begin
                    r_active[r_wslot] <= 1'b1;
                    r_wslot <= (r_wslot == '0) ? LAST_SLOT : r_wslot - AW'(1);
                    r_state <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (r_active[r_idx]) begin
                        r_state <= ST_LOAD;
                    end else if (r_idx == LAST_SLOT) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_LOAD: begin
                    if (life_le0) begin
                        r_active[r_idx] <= 1'b0;
                        if (r_idx == LAST_SLOT) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= ST_SCAN;
                        end
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: r_state <= ST_UPD;
                ST_UPD: r_state <= div_start ? ST_DIV : ST_MIX;
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_MIX;
                    end
                end
                ST_MIX: r_state <= ST_PUSH;
                ST_PUSH: begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_out_v    <= 1'b1;
                            r_out_last <= 1'b0;
                        end
                        r_pend_v <= 1'b1;
                        if (r_idx == LAST_SLOT) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_dt        <= s_axis_tdata[15:0];
            r_pos       <= s_axis_tdata[111:16];
            r_vel       <= s_axis_tdata[207:112];
            r_rand_rot  <= s_axis_tdata[223:208];
            r_rand_vel  <= s_axis_tdata[271:224];
            r_rand_size <= s_axis_tdata[287:272];
        end
        if (r_state == ST_EMUL) begin
            r_jx   <= $signed({1'b0, r_vel_var[15:0]})
                    * $signed({~r_rand_vel[15], r_rand_vel[14:0]});
            r_jy   <= $signed({1'b0, r_vel_var[31:16]})
                    * $signed({~r_rand_vel[31], r_rand_vel[30:16]});
            r_jz   <= $signed({1'b0, r_vel_var[47:32]})
                    * $signed({~r_rand_vel[47], r_rand_vel[46:32]});
            r_js   <= $signed({1'b0, r_size_var})
                    * $signed({~r_rand_size[15], r_rand_size[14:0]});
            r_rot0 <= {9'd0, r_rand_rot} * 25'd360;
        end
        if (r_state == ST_LOAD) begin
            r_ent <= rdata;
        end
        if (r_state == ST_MUL) begin
            r_mx   <= $signed(r_ent.vel_x) * $signed({1'b0, r_dt});
            r_my   <= $signed(r_ent.vel_y) * $signed({1'b0, r_dt});
            r_mz   <= $signed(r_ent.vel_z) * $signed({1'b0, r_dt});
            r_turn <= turn_prod[34:TURN_SHIFT];
            r_life <= r_ent.life_left - {17'd0, r_dt};
        end
        if (r_state == ST_UPD) begin
            r_ent.pos_x     <= sat32({{2{r_ent.pos_x[31]}}, r_ent.pos_x}
                                     + {r_mx[48], r_mx[48:16]});
            r_ent.pos_y     <= sat32({{2{r_ent.pos_y[31]}}, r_ent.pos_y}
                                     + {r_my[48], r_my[48:16]});
            r_ent.pos_z     <= sat32({{2{r_ent.pos_z[31]}}, r_ent.pos_z}
                                     + {r_mz[48], r_mz[48:16]});
            r_ent.rotation  <= r_ent.rotation + {21'd0, r_turn};
            r_ent.life_left <= r_life;
            if (r_life[32] || r_life == '0 || r_ent.life_total == '0) begin
                r_f <= '0;
            end else begin
                r_f <= 17'h10000;
            end
        end
        if (r_state == ST_DIV && div_done) begin
            r_f <= {1'b0, div_quot};
        end
        if (r_state == ST_MIX) begin
            r_res.center_x      <= r_ent.pos_x;
            r_res.center_y      <= r_ent.pos_y;
            r_res.center_z      <= r_ent.pos_z;
            r_res.rect_color    <= {mix8(r_ent.color_final[31:24], r_ent.color_start[31:24], r_f),
                                    mix8(r_ent.color_final[23:16], r_ent.color_start[23:16], r_f),
                                    mix8(r_ent.color_final[15:8],  r_ent.color_start[15:8],  r_f),
                                    mix8(r_ent.color_final[7:0],   r_ent.color_start[7:0],   r_f)};
            r_res.rect_size     <= mix16(r_ent.size_final, r_ent.size_start, r_f);
            r_res.rect_rotation <= r_ent.rotation;
        end
        if (r_state == ST_PUSH && (!r_pend_v || out_free)) begin
            r_pend <= r_res;
            if (r_pend_v) begin
                r_out <= r_pend;
            end
        end
        if (r_state == ST_FLUSH && r_pend_v && out_free) begin
            r_out <= r_pend;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {r_out.rect_rotation, r_out.rect_size, r_out.rect_color,
                            r_out.center_z, r_out.center_y, r_out.center_x};
endmodule
